// File: rtl/img_rle_scanline_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
// With SYNTH defined the macros expand to nothing.
`ifndef IMG_RLE_SCANLINE_DECODER_DEFINES_SVH
`define IMG_RLE_SCANLINE_DECODER_DEFINES_SVH

`ifndef SYNTH
`define IRSD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IRSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IRSD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define IRSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/imgrle_pkg.sv
package imgrle_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 8;
    localparam int MAX_LINE_BYTES_DEF    = 1024;
    localparam int QUEUE_DEPTH           = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LINE_BYTES     = 2'd0;
    localparam logic [1:0] CFG_PLANE_COUNT    = 2'd1;
    localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd2;
    localparam logic [1:0] CFG_IMAGE_LINES    = 2'd3;

    localparam logic [10:0] LINE_BYTES_RST     = 11'd80;
    localparam logic [3:0]  PLANE_COUNT_RST    = 4'd1;
    localparam logic [7:0]  PATTERN_LENGTH_RST = 8'd2;
    localparam logic [14:0] IMAGE_LINES_RST    = 15'd400;

    // Run kinds on the output.
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_SOLID   = 2'd1;
    localparam logic [1:0] KIND_PATTERN = 2'd2;
    localparam logic [1:0] KIND_MARKER  = 2'd3;

    // Special byte values of the stream.
    localparam logic [7:0] OPC_ZERO       = 8'h00;
    localparam logic [7:0] OPC_BIT_STRING = 8'h80;
    localparam logic [7:0] VRC_MARK       = 8'hFF;
    localparam logic [7:0] FILL_ONES      = 8'hFF;
    localparam logic [6:0] SOLID_LEN_MASK = 7'h7F;

    localparam logic [14:0] LINE_MAX = 15'h7FFF;

    // What the back end does with a command.
    typedef enum logic [1:0] {
        OP_CONSUME,   // advance the plane line by amount bytes
        OP_LITERAL,   // one literal byte, advances the line by one
        OP_NOADV,     // emit without touching the line position
        OP_REPEAT     // load the vertical replication count from amount
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op      op;
        logic [1:0]   kind;
        logic [63:0]  data;
        logic [3:0]   pbytes;
        logic [7:0]   reps;
        logic [15:0]  amount;
        logic         last;
    } t_cmd;

    typedef struct packed {
        logic [10:0] line_bytes;
        logic [3:0]  plane_count;
        logic [7:0]  pattern_length;
        logic [14:0] image_lines;
    } t_cfg;

endpackage

// File: rtl/imgrle_front.sv
module imgrle_front #(
    parameter int MAX_PATTERN_BYTES = imgrle_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_blocked,
    input  logic [7:0]        i_pattern_length,
    output logic              o_push,
    output imgrle_pkg::t_cmd  o_cmd,
    output logic              o_phase_idle
);
    import imgrle_pkg::*;

    localparam int SW   = 8 * MAX_PATTERN_BYTES;
    localparam int RC_W = $clog2(MAX_PATTERN_BYTES + 1);

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_AFTER_ZERO,
        PH_VRC_FF,
        PH_VRC_COUNT,
        PH_PATTERN,
        PH_BIT_COUNT,
        PH_BIT_DATA
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_pending, n_pending;
    logic [SW-1:0]   r_store, n_store;
    logic [RC_W-1:0] r_recv, n_recv;
    logic [7:0]      r_reps, n_reps;
    logic [15:0]     r_amount, n_amount;

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_store   = r_store;
        n_recv    = r_recv;
        n_reps    = r_reps;
        n_amount  = r_amount;
        o_push    = 1'b0;
        o_cmd     = '0;
        o_cmd.op  = OP_NOADV;
        if (i_accept && !i_blocked) begin
            case (r_phase)
                PH_OPCODE: begin
                    if (i_byte == OPC_ZERO) begin
                        n_phase = PH_AFTER_ZERO;
                    end else if (i_byte == OPC_BIT_STRING) begin
                        n_phase = PH_BIT_COUNT;
                    end else begin
                        o_push      = 1'b1;
                        o_cmd.op    = OP_CONSUME;
                        o_cmd.kind  = KIND_SOLID;
                        o_cmd.data  = i_byte[7] ? 64'(FILL_ONES) : 64'd0;
                        o_cmd.reps  = {1'b0, i_byte[6:0] & SOLID_LEN_MASK};
                        o_cmd.amount = 16'(i_byte[6:0] & SOLID_LEN_MASK);
                    end
                end
                PH_AFTER_ZERO: begin
                    if (i_byte == OPC_ZERO) begin
                        n_phase = PH_VRC_FF;
                    end else begin
                        n_reps   = i_byte;
                        n_store  = '0;
                        n_recv   = '0;
                        n_amount = 16'(i_byte) * 16'(i_pattern_length);
                        if (i_pattern_length == 8'd0) begin
                            n_phase     = PH_OPCODE;
                            o_push      = 1'b1;
                            o_cmd.op    = OP_NOADV;
                            o_cmd.kind  = KIND_PATTERN;
                            o_cmd.reps  = i_byte;
                        end else begin
                            n_pending = i_pattern_length;
                            n_phase   = PH_PATTERN;
                        end
                    end
                end
                PH_VRC_FF: begin
                    n_phase = (i_byte == VRC_MARK) ? PH_VRC_COUNT : PH_OPCODE;
                end
                PH_VRC_COUNT: begin
                    n_phase      = PH_OPCODE;
                    o_push       = 1'b1;
                    o_cmd.op     = OP_REPEAT;
                    o_cmd.kind   = KIND_MARKER;
                    o_cmd.amount = 16'((i_byte == 8'd0) ? 8'd1 : i_byte);
                end
                PH_PATTERN: begin
                    if (32'(r_recv) < MAX_PATTERN_BYTES) begin
                        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
                            if (r_recv == RC_W'(k)) begin
                                n_store[8*k +: 8] = i_byte;
                            end
                        end
                        n_recv = r_recv + RC_W'(1);
                    end
                    if (r_pending != 8'd0) begin
                        n_pending = r_pending - 8'd1;
                    end
                    if (n_pending == 8'd0) begin
                        n_phase      = PH_OPCODE;
                        o_push       = 1'b1;
                        o_cmd.op     = OP_CONSUME;
                        o_cmd.kind   = KIND_PATTERN;
                        o_cmd.data   = 64'(n_store);
                        o_cmd.pbytes = 4'(n_recv);
                        o_cmd.reps   = r_reps;
                        o_cmd.amount = r_amount;
                    end
                end
                PH_BIT_COUNT: begin
                    if (i_byte == 8'd0) begin
                        n_phase = PH_OPCODE;
                    end else begin
                        n_pending = i_byte;
                        n_phase   = PH_BIT_DATA;
                    end
                end
                PH_BIT_DATA: begin
                    if (r_pending != 8'd0) begin
                        n_pending = r_pending - 8'd1;
                    end
                    if (n_pending == 8'd0) begin
                        n_phase = PH_OPCODE;
                    end
                    o_push      = 1'b1;
                    o_cmd.op    = OP_LITERAL;
                    o_cmd.kind  = KIND_LITERAL;
                    o_cmd.data  = 64'(i_byte);
                    o_cmd.reps  = 8'd1;
                    o_cmd.last  = (n_pending == 8'd0);
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OPCODE;
            r_pending <= '0;
            r_store   <= '0;
            r_recv    <= '0;
            r_reps    <= '0;
            r_amount  <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_store   <= n_store;
            r_recv    <= n_recv;
            r_reps    <= n_reps;
            r_amount  <= n_amount;
        end
    end

    assign o_phase_idle = (r_phase == PH_OPCODE);

endmodule

// File: rtl/imgrle_queue.sv
`include "img_rle_scanline_decoder_defines.svh"

module imgrle_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  imgrle_pkg::t_cmd  i_cmd,
    input  logic              i_pop,
    output imgrle_pkg::t_cmd  o_head,
    output logic              o_not_empty,
    output logic              o_full
);
    import imgrle_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] f_wrap(input logic [PTR_W-1:0] p);
        f_wrap = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_wrap(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_wrap(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head      = r_mem[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_full      = (r_count == CNT_W'(QUEUE_DEPTH));

    `IRSD_ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop)
    `IRSD_ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, o_not_empty)

endmodule

// File: rtl/imgrle_back.sv
`include "img_rle_scanline_decoder_defines.svh"

module imgrle_back #(
    parameter int MAX_LINE_BYTES = imgrle_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  imgrle_pkg::t_cfg  i_cfg,
    input  logic              i_line_write,
    input  logic [10:0]       i_line_data,
    input  logic              i_phase_idle,
    input  imgrle_pkg::t_cmd  i_head,
    input  logic              i_head_valid,
    output logic              o_pop,
    output logic              o_blocked,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_run_kind,
    output logic [63:0]       o_run_data,
    output logic [3:0]        o_pattern_bytes,
    output logic [7:0]        o_repeat_count,
    output logic [2:0]        o_plane_index,
    output logic [14:0]       o_line_index,
    output logic              o_plane_line_end,
    output logic              o_row_end,
    output logic [7:0]        o_replicate_lines,
    output logic              o_image_done
);
    import imgrle_pkg::*;

    localparam int BL_W = $clog2(MAX_LINE_BYTES + 1);

    function automatic logic [BL_W-1:0] f_eff_line(input logic [10:0] v);
        if (v == 11'd0) begin
            f_eff_line = BL_W'(1);
        end else if (32'(v) > MAX_LINE_BYTES) begin
            f_eff_line = BL_W'(MAX_LINE_BYTES);
        end else begin
            f_eff_line = BL_W'(v);
        end
    endfunction

    logic [BL_W-1:0] r_bytes_left, n_bytes_left;
    logic [2:0]      r_plane, n_plane;
    logic [14:0]     r_line, n_line;
    logic [7:0]      r_repeat, n_repeat;
    logic            r_finished, n_finished;
    logic            r_out_valid;

    logic [3:0]      eff_planes;
    logic [15:0]     line_sum;
    logic [14:0]     next_line;
    logic            pend, row, done;
    logic [7:0]      rep_out;
    logic            fresh;

    always_comb begin
        if (i_cfg.plane_count == 4'd0) begin
            eff_planes = 4'd1;
        end else if (i_cfg.plane_count > 4'd8) begin
            eff_planes = 4'd8;
        end else begin
            eff_planes = i_cfg.plane_count;
        end
    end

    assign line_sum  = 16'(r_line) + 16'(r_repeat);
    assign next_line = (line_sum > 16'(LINE_MAX)) ? LINE_MAX : line_sum[14:0];

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_plane      = r_plane;
        n_line       = r_line;
        n_repeat     = r_repeat;
        n_finished   = r_finished;
        pend         = 1'b0;
        row          = 1'b0;
        done         = 1'b0;
        rep_out      = r_repeat;
        case (i_head.op)
            OP_CONSUME: begin
                if (i_head.amount >= 16'(r_bytes_left)) begin
                    pend         = 1'b1;
                    n_bytes_left = '0;
                end else begin
                    n_bytes_left = r_bytes_left - BL_W'(i_head.amount);
                end
            end
            OP_LITERAL: begin
                if (r_bytes_left != '0) begin
                    n_bytes_left = r_bytes_left - BL_W'(1);
                end
                pend = i_head.last && (n_bytes_left == '0);
            end
            OP_REPEAT: begin
                n_repeat = i_head.amount[7:0];
                rep_out  = i_head.amount[7:0];
            end
            default: begin
            end
        endcase
        if (pend) begin
            n_bytes_left = f_eff_line(i_cfg.line_bytes);
            if (4'(r_plane) + 4'd1 >= eff_planes) begin
                row      = 1'b1;
                n_line   = next_line;
                n_plane  = '0;
                n_repeat = 8'd1;
                if (next_line >= i_cfg.image_lines) begin
                    n_finished = 1'b1;
                    done       = 1'b1;
                end
            end else begin
                n_plane = r_plane + 3'd1;
            end
        end
    end

    assign o_pop     = i_head_valid && (!r_out_valid || i_ready);
    assign o_blocked = r_finished || (r_line >= i_cfg.image_lines);
    assign fresh     = i_phase_idle && (r_bytes_left == f_eff_line(i_cfg.line_bytes));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= f_eff_line(LINE_BYTES_RST);
            r_plane      <= '0;
            r_line       <= '0;
            r_repeat     <= 8'd1;
            r_finished   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop && !r_finished) begin
                r_bytes_left <= n_bytes_left;
                r_plane      <= n_plane;
                r_line       <= n_line;
                r_repeat     <= n_repeat;
                r_finished   <= n_finished;
            end else if (i_line_write && fresh) begin
                r_bytes_left <= f_eff_line(i_line_data);
            end
            if (o_pop) begin
                r_out_valid <= !r_finished;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !r_finished) begin
            o_run_kind        <= i_head.kind;
            o_run_data        <= i_head.data;
            o_pattern_bytes   <= i_head.pbytes;
            o_repeat_count    <= i_head.reps;
            o_plane_index     <= r_plane;
            o_line_index      <= r_line;
            o_plane_line_end  <= pend;
            o_row_end         <= row;
            o_replicate_lines <= rep_out;
            o_image_done      <= done;
        end
    end

    assign o_valid = r_out_valid;

    `IRSD_ASSERT_NEXT(a_finished_sticky, i_clk, i_rst_n, r_finished, r_finished)
    `IRSD_ASSERT_IMPLIES(a_row_has_line_end, i_clk, i_rst_n, r_out_valid && o_row_end, o_plane_line_end)
    `IRSD_ASSERT_IMPLIES(a_left_in_range, i_clk, i_rst_n, 1'b1, 32'(r_bytes_left) <= MAX_LINE_BYTES)
    `IRSD_ASSERT_NEXT(a_no_run_after_done, i_clk, i_rst_n, r_finished, !(o_pop && !r_finished))

endmodule

// File: rtl/img_rle_scanline_decoder.sv
// Run-length decoder for bitmap scanlines: takes one compressed byte per transaction on
// the code channel and delivers at most one run descriptor per byte on the run channel
// (literal byte, solid fill run, pattern run, or a marker carrying a new vertical
// replication count), tagged with plane, line and end-of-plane-line, end-of-row and
// end-of-image flags. A new byte is accepted every cycle as long as the two-entry command
// queue between the parser and the line tracker has room, so the sustained rate is one
// byte per clock when the consumer takes runs every cycle. A descriptor is registered
// first in the command queue and then in the output register, where it is held until
// the run channel takes it. The code ready signal depends only on the queue fill level,
// never on the run channel directly. Bytes after the image is complete are accepted and
// dropped. The configuration registers (line bytes, plane count, pattern length, image
// lines) are written through a simple write port and may only change while no
// transaction is in flight. At most MAX_PATTERN_BYTES pattern bytes are kept per
// pattern run; the line width is clamped to MAX_LINE_BYTES.
module img_rle_scanline_decoder #(
    parameter int MAX_PATTERN_BYTES = imgrle_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int MAX_LINE_BYTES    = imgrle_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    input  logic        i_code_valid,
    output logic        o_code_ready,
    input  logic [7:0]  i_code_byte,
    output logic        o_run_valid,
    input  logic        i_run_ready,
    output logic [1:0]  o_run_kind,
    output logic [63:0] o_run_data,
    output logic [3:0]  o_pattern_bytes,
    output logic [7:0]  o_repeat_count,
    output logic [2:0]  o_plane_index,
    output logic [14:0] o_line_index,
    output logic        o_plane_line_end,
    output logic        o_row_end,
    output logic [7:0]  o_replicate_lines,
    output logic        o_image_done
);
    import imgrle_pkg::*;

    // Configuration registers.
    t_cfg r_cfg;

    // Handshake and internal connections.
    logic accept;
    logic push, pop, blocked, phase_idle;
    logic q_not_empty, q_full;
    t_cmd push_cmd, head_cmd;
    logic line_write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_bytes     <= LINE_BYTES_RST;
            r_cfg.plane_count    <= PLANE_COUNT_RST;
            r_cfg.pattern_length <= PATTERN_LENGTH_RST;
            r_cfg.image_lines    <= IMAGE_LINES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_BYTES:     r_cfg.line_bytes     <= i_cfg_data[10:0];
                CFG_PLANE_COUNT:    r_cfg.plane_count    <= i_cfg_data[3:0];
                CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_data[7:0];
                CFG_IMAGE_LINES:    r_cfg.image_lines    <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // A line width write also reloads the byte count of a plane line that has not
    // started yet; the back end decides that against the old width.
    assign line_write = i_cfg_we && (i_cfg_index == CFG_LINE_BYTES);

    assign o_code_ready = !q_full;
    assign accept       = i_code_valid && o_code_ready;

    // The front end parses record headers and collects pattern and literal bytes.
    imgrle_front #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_byte           (i_code_byte),
        .i_blocked        (blocked),
        .i_pattern_length (r_cfg.pattern_length),
        .o_push           (push),
        .o_cmd            (push_cmd),
        .o_phase_idle     (phase_idle)
    );

    imgrle_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (push_cmd),
        .i_pop       (pop),
        .o_head      (head_cmd),
        .o_not_empty (q_not_empty),
        .o_full      (q_full)
    );

    // The back end tracks the position in the plane line, the plane and the line, and
    // drops commands that arrive after the image is complete.
    imgrle_back #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_line_write      (line_write),
        .i_line_data       (i_cfg_data[10:0]),
        .i_phase_idle      (phase_idle),
        .i_head            (head_cmd),
        .i_head_valid      (q_not_empty),
        .o_pop             (pop),
        .o_blocked         (blocked),
        .o_valid           (o_run_valid),
        .i_ready           (i_run_ready),
        .o_run_kind        (o_run_kind),
        .o_run_data        (o_run_data),
        .o_pattern_bytes   (o_pattern_bytes),
        .o_repeat_count    (o_repeat_count),
        .o_plane_index     (o_plane_index),
        .o_line_index      (o_line_index),
        .o_plane_line_end  (o_plane_line_end),
        .o_row_end         (o_row_end),
        .o_replicate_lines (o_replicate_lines),
        .o_image_done      (o_image_done)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import imgrle_pkg::*;

    // Handshake limits and phase sizing.
    localparam int SETTLE_CYCLES   = 8;     // covers the two-stage pipeline with margin
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 13;
    localparam int PHASE_BYTES     = 100;
    localparam int LINE_SATURATE   = 32'h7FFF;

    // Parser position inside a record, mirrored from the decoder's behavior.
    typedef enum logic [2:0] {
        PS_OPCODE,
        PS_AFTER_ZERO,
        PS_VRC_FF,
        PS_VRC_COUNT,
        PS_PATTERN,
        PS_BIT_COUNT,
        PS_BIT_DATA
    } t_parse_st;

    // One run descriptor as it should appear on the run channel.
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] data;
        logic [3:0]  pbytes;
        logic [7:0]  reps;
        logic [2:0]  plane;
        logic [14:0] line;
        logic        pend;
        logic        row;
        logic [7:0]  repl;
        logic        done;
    } t_run;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_LINE_BYTES;
    logic [14:0] i_cfg_data = '0;
    logic        i_code_valid = 1'b0;
    logic        o_code_ready;
    logic [7:0]  i_code_byte = '0;
    logic        o_run_valid;
    logic        i_run_ready = 1'b0;
    logic [1:0]  o_run_kind;
    logic [63:0] o_run_data;
    logic [3:0]  o_pattern_bytes;
    logic [7:0]  o_repeat_count;
    logic [2:0]  o_plane_index;
    logic [14:0] o_line_index;
    logic        o_plane_line_end;
    logic        o_row_end;
    logic [7:0]  o_replicate_lines;
    logic        o_image_done;

    img_rle_scanline_decoder u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_code_valid     (i_code_valid),
        .o_code_ready     (o_code_ready),
        .i_code_byte      (i_code_byte),
        .o_run_valid      (o_run_valid),
        .i_run_ready      (i_run_ready),
        .o_run_kind       (o_run_kind),
        .o_run_data       (o_run_data),
        .o_pattern_bytes  (o_pattern_bytes),
        .o_repeat_count   (o_repeat_count),
        .o_plane_index    (o_plane_index),
        .o_line_index     (o_line_index),
        .o_plane_line_end (o_plane_line_end),
        .o_row_end        (o_row_end),
        .o_replicate_lines(o_replicate_lines),
        .o_image_done     (o_image_done)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Compressed bytes waiting to be driven, and run descriptors that the decoder owes us.
    logic [7:0] byte_stream[$];
    t_run       pending_runs[$];

    int mismatch_count = 0;
    int runs_seen      = 0;
    int idle_pct       = 0;     // chance in percent that a stall burst starts on a cycle
    int code_gap       = 0;
    int ready_gap      = 0;
    int stall_cycles   = 0;

    // Decoder state as predicted by the testbench. Initial values match reset.
    t_cfg        cfg = '{LINE_BYTES_RST, PLANE_COUNT_RST, PATTERN_LENGTH_RST, IMAGE_LINES_RST};
    t_parse_st   dec_phase       = PS_OPCODE;
    logic [7:0]  dec_pending     = '0;
    logic [63:0] pat_store       = '0;
    int          pat_count       = 0;
    logic [7:0]  pat_reps        = '0;
    logic [7:0]  pat_len_latched = '0;
    int          line_left       = int'(LINE_BYTES_RST);
    int          cur_plane       = 0;
    int          cur_line        = 0;
    logic [7:0]  line_rep        = 8'd1;
    bit          img_finished    = 1'b0;

    // Effective line width: zero counts as one byte, anything past the maximum is clamped.
    function automatic int eff_line_bytes();
        if (cfg.line_bytes == 0) return 1;
        if (cfg.line_bytes > MAX_LINE_BYTES_DEF) return MAX_LINE_BYTES_DEF;
        return int'(cfg.line_bytes);
    endfunction

    function automatic int eff_planes();
        if (cfg.plane_count == 0) return 1;
        if (cfg.plane_count > 8) return 8;
        return int'(cfg.plane_count);
    endfunction

    // Advances the plane line; a run that reaches or overshoots the end closes the line.
    function automatic bit take_bytes(int amount);
        if (amount >= line_left) begin
            line_left = 0;
            return 1'b1;
        end
        line_left -= amount;
        return 1'b0;
    endfunction

    // Builds the descriptor and, when it closes a plane line, steps plane, line and the
    // replication count. The descriptor carries the position from before the step.
    function automatic t_run close_run(logic [1:0] kind, logic [63:0] data,
                                       logic [3:0] pbytes, logic [7:0] reps, bit pend);
        t_run r;
        int   next_line;
        r        = '0;
        r.kind   = kind;
        r.data   = data;
        r.pbytes = pbytes;
        r.reps   = reps;
        r.plane  = cur_plane[2:0];
        r.line   = cur_line[14:0];
        r.pend   = pend;
        r.repl   = line_rep;
        if (pend) begin
            line_left = eff_line_bytes();
            if (cur_plane + 1 >= eff_planes()) begin
                next_line = cur_line + int'(line_rep);
                if (next_line > LINE_SATURATE) next_line = LINE_SATURATE;
                r.row     = 1'b1;
                cur_line  = next_line;
                cur_plane = 0;
                line_rep  = 8'd1;
                if (cur_line >= cfg.image_lines) begin
                    img_finished = 1'b1;
                    r.done       = 1'b1;
                end
            end else begin
                cur_plane++;
            end
        end
        return r;
    endfunction

    // Feeds one compressed byte to the prediction. Returns 1 when the byte yields a run.
    function automatic bit decode_code_byte(logic [7:0] b, output t_run r);
        bit pend;
        r = '0;
        // Once the configured line count is reached every byte is dropped.
        if (img_finished || cur_line >= cfg.image_lines) return 1'b0;
        case (dec_phase)
            PS_OPCODE: begin
                if (b == OPC_ZERO) begin
                    dec_phase = PS_AFTER_ZERO;
                    return 1'b0;
                end
                if (b == OPC_BIT_STRING) begin
                    dec_phase = PS_BIT_COUNT;
                    return 1'b0;
                end
                pend = take_bytes(int'(b[6:0]));
                r = close_run(KIND_SOLID, {56'd0, {8{b[7]}}}, 4'd0, {1'b0, b[6:0]}, pend);
                return 1'b1;
            end
            PS_AFTER_ZERO: begin
                if (b == OPC_ZERO) begin
                    dec_phase = PS_VRC_FF;
                    return 1'b0;
                end
                // Pattern run header: the pattern length is latched here.
                pat_reps        = b;
                pat_store       = '0;
                pat_count       = 0;
                pat_len_latched = cfg.pattern_length;
                if (pat_len_latched == 0) begin
                    dec_phase = PS_OPCODE;
                    r = close_run(KIND_PATTERN, 64'd0, 4'd0, b, 1'b0);
                    return 1'b1;
                end
                dec_pending = pat_len_latched;
                dec_phase   = PS_PATTERN;
                return 1'b0;
            end
            PS_VRC_FF: begin
                // Anything but the marker drops the replication record silently.
                dec_phase = (b == VRC_MARK) ? PS_VRC_COUNT : PS_OPCODE;
                return 1'b0;
            end
            PS_VRC_COUNT: begin
                line_rep  = (b == 8'd0) ? 8'd1 : b;
                dec_phase = PS_OPCODE;
                r = close_run(KIND_MARKER, 64'd0, 4'd0, 8'd0, 1'b0);
                return 1'b1;
            end
            PS_PATTERN: begin
                // Only the first few pattern bytes are kept; the rest are just counted.
                if (pat_count < MAX_PATTERN_BYTES_DEF) begin
                    pat_store |= {56'd0, b} << (8 * pat_count);
                    pat_count++;
                end
                if (dec_pending > 0) dec_pending--;
                if (dec_pending == 0) begin
                    pend      = take_bytes(int'(pat_reps) * int'(pat_len_latched));
                    dec_phase = PS_OPCODE;
                    r = close_run(KIND_PATTERN, pat_store, 4'(pat_count), pat_reps, pend);
                    return 1'b1;
                end
                return 1'b0;
            end
            PS_BIT_COUNT: begin
                if (b == 8'd0) begin
                    dec_phase = PS_OPCODE;
                    return 1'b0;
                end
                dec_pending = b;
                dec_phase   = PS_BIT_DATA;
                return 1'b0;
            end
            PS_BIT_DATA: begin
                // A bit string is never cut at the line end; the flag lands on its last byte.
                if (line_left > 0) line_left--;
                if (dec_pending > 0) dec_pending--;
                pend = (dec_pending == 0) && (line_left == 0);
                if (dec_pending == 0) dec_phase = PS_OPCODE;
                r = close_run(KIND_LITERAL, {56'd0, b}, 4'd0, 8'd1, pend);
                return 1'b1;
            end
            default: begin
                dec_phase = PS_OPCODE;
                return 1'b0;
            end
        endcase
    endfunction

    // Register write as seen by the prediction. A new line width also reloads the
    // remaining count when the current plane line has not been touched yet.
    function automatic void write_cfg_model(logic [1:0] idx, logic [14:0] val);
        bit fresh;
        fresh = (dec_phase == PS_OPCODE) && (line_left == eff_line_bytes());
        case (idx)
            CFG_LINE_BYTES: begin
                cfg.line_bytes = val[10:0];
                if (fresh) line_left = eff_line_bytes();
            end
            CFG_PLANE_COUNT:    cfg.plane_count = val[3:0];
            CFG_PATTERN_LENGTH: cfg.pattern_length = val[7:0];
            CFG_IMAGE_LINES:    cfg.image_lines = val;
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR run %0d %s: got 0x%0h, expected 0x%0h", runs_seen, what, got, want);
        mismatch_count++;
    endtask

    // Writes one register. Bits above the register width carry random junk, which the
    // decoder must ignore.
    task automatic set_reg(input logic [1:0] idx, input int value);
        logic [14:0] data;
        data = 15'($urandom);
        case (idx)
            CFG_LINE_BYTES:     data[10:0] = value[10:0];
            CFG_PLANE_COUNT:    data[3:0]  = value[3:0];
            CFG_PATTERN_LENGTH: data[7:0]  = value[7:0];
            CFG_IMAGE_LINES:    data       = value[14:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        write_cfg_model(idx, data);
    endtask

    // Waits until every queued byte went in and every owed run came out, then lets the
    // pipeline settle, since the last bytes may be mid-record and produce nothing.
    // The check runs on the falling edge so it never races the clocked processes.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (byte_stream.size() != 0 || i_code_valid || pending_runs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Appends one well-formed record with random content, or a little noise.
    // Returns the number of bytes added.
    function automatic int add_record();
        int         sel;
        int         n;
        logic [6:0] len;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            // Solid run: the length is never zero, so the byte is never an opcode.
            len = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(1, 8))
                                              : 7'($urandom_range(1, 127));
            byte_stream.push_back({1'($urandom), len});
            return 1;
        end
        if (sel < 60) begin
            case ($urandom_range(0, 79))
                0:       n = 0;
                1:       n = 255;
                default: n = $urandom_range(1, 8);
            endcase
            byte_stream.push_back(OPC_BIT_STRING);
            byte_stream.push_back(8'(n));
            repeat (n) byte_stream.push_back(8'($urandom));
            return n + 2;
        end
        if (sel < 80) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
            byte_stream.push_back(OPC_ZERO);
            byte_stream.push_back(8'(n));
            repeat (cfg.pattern_length) byte_stream.push_back(8'($urandom));
            return 2 + cfg.pattern_length;
        end
        if (sel < 88) begin
            // Mostly small replication counts so the image does not end early.
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
            byte_stream.push_back(OPC_ZERO);
            byte_stream.push_back(OPC_ZERO);
            byte_stream.push_back(VRC_MARK);
            byte_stream.push_back(8'(n));
            return 4;
        end
        if (sel < 92) begin
            // Broken replication record: the marker byte is wrong.
            byte_stream.push_back(OPC_ZERO);
            byte_stream.push_back(OPC_ZERO);
            byte_stream.push_back(8'($urandom_range(0, 254)));
            return 3;
        end
        byte_stream.push_back(8'($urandom));
        return 1;
    endfunction

    // Directed stream at reset configuration (80-byte lines, one plane, 2-byte patterns):
    // both solid fills, an overrunning solid run that ends the line, a bit string that
    // crosses the line end, an empty bit string, replication counts of zero and of the
    // maximum, a broken replication record, and a regular pattern run.
    localparam logic [7:0] DIRECTED_BASIC [26] = '{
        8'h05, 8'h85, 8'hFF, 8'hCE,
        OPC_BIT_STRING, 8'h03, 8'h01, 8'h80, 8'hFF,
        OPC_BIT_STRING, OPC_ZERO,
        OPC_ZERO, OPC_ZERO, VRC_MARK, 8'h00,
        OPC_ZERO, OPC_ZERO, VRC_MARK, 8'hFF,
        OPC_ZERO, OPC_ZERO, 8'h12,
        OPC_ZERO, 8'h03, 8'hC3, 8'h3C
    };
    // A ten-byte pattern split across a change of the pattern length: the first part
    // carries the header, the second part must still be counted with the latched length.
    localparam logic [7:0] LONG_PATTERN_HEAD [6] = '{
        OPC_ZERO, 8'h02, 8'h11, 8'h22, 8'h44, 8'h88
    };
    localparam logic [7:0] LONG_PATTERN_TAIL [6] = '{
        8'hFE, 8'hDC, 8'hBA, 8'h98, 8'h76, 8'h54
    };

    // Driver: presents the next queued byte whenever the channel is free. Each accepted
    // transaction is run through the prediction right away.
    always @(posedge i_clk) begin
        t_run run_exp;
        if (!i_rst_n) begin
            i_code_valid <= 1'b0;
            code_gap = 0;
        end else begin
            if (i_code_valid && o_code_ready) begin
                if (decode_code_byte(i_code_byte, run_exp)) pending_runs.push_back(run_exp);
            end
            // The slot is free when nothing is offered or the offer was just taken.
            if (!i_code_valid || o_code_ready) begin
                if (code_gap > 0) begin
                    code_gap--;
                    i_code_valid <= 1'b0;
                end else if (byte_stream.size() != 0 && idle_pct != 0 &&
                             $urandom_range(0, 99) < idle_pct) begin
                    code_gap = $urandom_range(0, 15);
                    i_code_valid <= 1'b0;
                end else if (byte_stream.size() != 0) begin
                    i_code_valid <= 1'b1;
                    i_code_byte  <= byte_stream.pop_front();
                end else begin
                    i_code_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted run against the oldest prediction, field by field,
    // and throttles the run channel with random stall bursts.
    always @(posedge i_clk) begin
        t_run want;
        if (!i_rst_n) begin
            i_run_ready <= 1'b0;
            ready_gap = 0;
        end else begin
            if (o_run_valid && i_run_ready) begin
                runs_seen++;
                if (pending_runs.size() == 0) begin
                    report_mismatch("unexpected run, run_data", o_run_data, 64'd0);
                end else begin
                    want = pending_runs.pop_front();
                    if (o_run_kind !== want.kind)
                        report_mismatch("run_kind", 64'(o_run_kind), 64'(want.kind));
                    if (o_run_data !== want.data)
                        report_mismatch("run_data", o_run_data, want.data);
                    if (o_pattern_bytes !== want.pbytes)
                        report_mismatch("pattern_bytes", 64'(o_pattern_bytes),
                                        64'(want.pbytes));
                    if (o_repeat_count !== want.reps)
                        report_mismatch("repeat_count", 64'(o_repeat_count), 64'(want.reps));
                    if (o_plane_index !== want.plane)
                        report_mismatch("plane_index", 64'(o_plane_index), 64'(want.plane));
                    if (o_line_index !== want.line)
                        report_mismatch("line_index", 64'(o_line_index), 64'(want.line));
                    if (o_plane_line_end !== want.pend)
                        report_mismatch("plane_line_end", 64'(o_plane_line_end),
                                        64'(want.pend));
                    if (o_row_end !== want.row)
                        report_mismatch("row_end", 64'(o_row_end), 64'(want.row));
                    if (o_replicate_lines !== want.repl)
                        report_mismatch("replicate_lines", 64'(o_replicate_lines),
                                        64'(want.repl));
                    if (o_image_done !== want.done)
                        report_mismatch("image_done", 64'(o_image_done), 64'(want.done));
                end
            end
            if (ready_gap > 0) begin
                ready_gap--;
                i_run_ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                ready_gap = $urandom_range(0, 15);
                i_run_ready <= 1'b0;
            end else begin
                i_run_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hang shows up as a long stretch with no transaction and no write.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_code_valid && o_code_ready) || (o_run_valid && i_run_ready) ||
            i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d runs still owed",
                     stall_cycles, pending_runs.size());
            $display("tb_top NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus sequence. Registers are only written once the decoder has drained.
    initial begin
        int sent;
        int rows;
        int lb;
        int pc;
        int pl;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset configuration, no stalls.
        foreach (DIRECTED_BASIC[i]) byte_stream.push_back(DIRECTED_BASIC[i]);
        wait_quiet();

        // Raise the line limit so the pending replication of 255 cannot end the image.
        set_reg(CFG_IMAGE_LINES, LINE_SATURATE);

        // Zero pattern length: the run comes out on its count byte and moves nothing.
        set_reg(CFG_PATTERN_LENGTH, 0);
        byte_stream.push_back(OPC_ZERO);
        byte_stream.push_back(8'h05);
        wait_quiet();

        // Long pattern, and a length change in the middle of the record.
        set_reg(CFG_PATTERN_LENGTH, 10);
        foreach (LONG_PATTERN_HEAD[i]) byte_stream.push_back(LONG_PATTERN_HEAD[i]);
        wait_quiet();
        set_reg(CFG_PATTERN_LENGTH, 1);
        foreach (LONG_PATTERN_TAIL[i]) byte_stream.push_back(LONG_PATTERN_TAIL[i]);
        wait_quiet();

        // Zero image lines, then a limit below the current line: all bytes are dropped.
        set_reg(CFG_IMAGE_LINES, 0);
        repeat (6) byte_stream.push_back(8'($urandom));
        wait_quiet();
        set_reg(CFG_IMAGE_LINES, 1);
        repeat (4) byte_stream.push_back(8'($urandom));
        wait_quiet();
        set_reg(CFG_IMAGE_LINES, LINE_SATURATE);

        // Random phases. Each one walks the configuration through its extremes and picks
        // a stall profile; the last phases run without stalls.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p >= RANDOM_PHASES - 3) idle_pct = 0;
            else if (p % 3 == 0)        idle_pct = 0;
            else if (p % 3 == 1)        idle_pct = 6;
            else                        idle_pct = 30;

            case (p % 6)
                0:       lb = 0;
                1:       lb = 2047;
                2:       lb = MAX_LINE_BYTES_DEF;
                3:       lb = 1;
                default: lb = $urandom_range(1, 24);
            endcase
            case (p % 5)
                0:       pc = 0;
                1:       pc = 15;
                2:       pc = 8;
                3:       pc = 1;
                default: pc = $urandom_range(0, 15);
            endcase
            case (p % 5)
                0:       pl = 0;
                1:       pl = 255;
                2:       pl = 1;
                3:       pl = MAX_PATTERN_BYTES_DEF;
                default: pl = $urandom_range(2, 12);
            endcase
            set_reg(CFG_LINE_BYTES, lb);
            set_reg(CFG_PLANE_COUNT, pc);
            set_reg(CFG_PATTERN_LENGTH, pl);

            sent = 0;
            while (sent < PHASE_BYTES) sent += add_record();

            // Sometimes stop inside a record so the next register writes land mid-record.
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: byte_stream.push_back(OPC_ZERO);
                    1: begin
                        byte_stream.push_back(OPC_BIT_STRING);
                        byte_stream.push_back(8'($urandom_range(2, 4)));
                        byte_stream.push_back(8'($urandom));
                    end
                    2: begin
                        byte_stream.push_back(OPC_ZERO);
                        byte_stream.push_back(OPC_ZERO);
                    end
                    default: begin
                        byte_stream.push_back(OPC_ZERO);
                        byte_stream.push_back(8'($urandom_range(1, 9)));
                    end
                endcase
            end
            wait_quiet();
        end

        // Closing phase: one-byte lines on a single plane, rows replicated 255 times, until
        // the line counter saturates and the image completes. Bytes after that are dropped.
        idle_pct = 0;
        set_reg(CFG_LINE_BYTES, 1);
        set_reg(CFG_PLANE_COUNT, 1);
        set_reg(CFG_PATTERN_LENGTH, 1);
        // Finish any record left open by the last random phase. A finished image no
        // longer parses anything, so there is nothing left to close then.
        while (dec_phase != PS_OPCODE && !img_finished) begin
            byte_stream.push_back(8'h01);
            wait_quiet();
        end
        // The current line may still hold up to a full maximum width.
        repeat (9) byte_stream.push_back(8'hFF);
        wait_quiet();
        rows = (LINE_SATURATE - cur_line) / 255 + 2;
        repeat (rows) begin
            byte_stream.push_back(OPC_ZERO);
            byte_stream.push_back(OPC_ZERO);
            byte_stream.push_back(VRC_MARK);
            byte_stream.push_back(8'hFF);
            byte_stream.push_back(8'hFF);
        end
        repeat (8) byte_stream.push_back(8'($urandom));
        wait_quiet();
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
